>>> sv/prefix_expression_evaluator_assert.svh
`ifndef PREFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define PREFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PEXPR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prefix expression evaluator check failed");

// next-cycle implication, sampled on clk, off during reset
`define PEXPR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prefix expression evaluator check failed");

`endif

>>> sv/pexpr_pkg.sv
package pexpr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] DIV_LAST_STEP = 5'd31;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam int unsigned MARK_FULL  = 0;
  localparam int unsigned MARK_EMPTY = 1;
  localparam int unsigned MARK_DIV0  = 2;
  localparam int unsigned MARK_W     = 3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     stack_full_seen;
    logic                     stack_empty_seen;
    logic                     divide_by_zero_seen;
    logic                     stopped_on_unknown;
  } out_t;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_RD_L    = 10'b00_0000_0010,
    ST_RD_R    = 10'b00_0000_0100,
    ST_POP     = 10'b00_0000_1000,
    ST_ALU     = 10'b00_0001_0000,
    ST_DIV     = 10'b00_0010_0000,
    ST_DIV_FIX = 10'b00_0100_0000,
    ST_PUSH    = 10'b00_1000_0000,
    ST_RD_TOP  = 10'b01_0000_0000,
    ST_OUT     = 10'b10_0000_0000
  } state_t;

endpackage

>>> sv/prefix_expression_evaluator.sv
// Prefix expression evaluator. Characters arrive rightmost first, one request
// each; final_char marks the leftmost one. Digits push onto a STACK_DEPTH-entry
// operand memory, + - * / pop two operands (top is the left one) and push the
// wrapped 32-bit result, any other character pops two operands, stops the
// expression and reports the new top. One result request follows the final (or
// stopping) character. A digit is handled in its accept cycle; + - * go through
// the read, pop, ALU and push states, and / through a radix-2 restoring divider,
// one quotient bit per cycle, or straight to the push on a zero divisor; the
// final or stopping character then waits for the top-of-stack memory read, and
// longer while an earlier result has not been taken. in_ready is low while a
// character is in work. The result sits in an output register, so the next
// character is taken while a result waits to be taken.
`include "prefix_expression_evaluator_assert.svh"

module prefix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pexpr_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pexpr_pkg::out_t  out_data
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = pexpr_pkg::DATA_W;
  localparam int unsigned SW = pexpr_pkg::STEP_W;
  localparam int unsigned MW = pexpr_pkg::MARK_W;

  pexpr_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [MW-1:0]     marks_r, marks_nxt;
  logic              skip_r, skip_nxt;
  logic              out_valid_r, out_valid_nxt;
  pexpr_pkg::out_t   out_r, out_nxt;

  logic [7:0]        char_r, char_nxt;
  logic              last_r, last_nxt;
  logic              unk_r, unk_nxt;
  logic [DW-1:0]     left_r, left_nxt;
  logic [DW-1:0]     right_r, right_nxt;
  logic [DW-1:0]     res_r, res_nxt;
  logic [DW-1:0]     quo_r, quo_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic [SW-1:0]     step_r, step_nxt;

  logic [DW-1:0]     mem [STACK_DEPTH];
  logic [DW-1:0]     rdata_r;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DW-1:0]     wdata;
  logic [AW-1:0]     raddr;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;

  logic              is_digit;
  logic              has_two;
  logic              is_full;
  logic [7:0]        digit_val;
  logic [DW-1:0]     right_val;
  logic [DW:0]       rem_sh;
  logic [DW+1:0]     diff;

  assign cnt_m1    = count_r - CW'(1);
  assign cnt_m2    = count_r - CW'(2);
  assign raddr     = (state_r == pexpr_pkg::ST_RD_R) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
  assign has_two   = (count_r >= CW'(2));
  assign is_full   = (count_r == CW'(STACK_DEPTH));
  assign is_digit  = (in_data.char_code >= pexpr_pkg::CH_ZERO) &&
                     (in_data.char_code <= pexpr_pkg::CH_NINE);
  assign digit_val = in_data.char_code - pexpr_pkg::CH_ZERO;
  assign right_val = has_two ? rdata_r : '0;
  assign rem_sh    = {rem_r, quo_r[DW-1]};
  assign diff      = {1'b0, rem_sh} - {2'b00, dvs_r};

  assign in_ready  = (state_r == pexpr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    marks_nxt     = marks_r;
    skip_nxt      = skip_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_nxt       = out_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    unk_nxt       = unk_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    res_nxt       = res_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    we            = 1'b0;
    waddr         = count_r[AW-1:0];
    wdata         = res_r;
    case (state_r)
      pexpr_pkg::ST_IDLE: begin
        if (in_valid) begin
          char_nxt = in_data.char_code;
          last_nxt = in_data.final_char;
          unk_nxt  = 1'b0;
          if (skip_r) begin
            if (in_data.final_char) begin
              count_nxt = '0;
              marks_nxt = '0;
              skip_nxt  = 1'b0;
            end
          end else if (is_digit) begin
            if (is_full) begin
              marks_nxt[pexpr_pkg::MARK_FULL] = 1'b1;
            end else begin
              we        = 1'b1;
              wdata     = {{(DW-8){1'b0}}, digit_val};
              count_nxt = count_r + CW'(1);
            end
            if (in_data.final_char) begin
              state_nxt = pexpr_pkg::ST_RD_TOP;
            end
          end else begin
            state_nxt = pexpr_pkg::ST_RD_L;
          end
        end
      end
      pexpr_pkg::ST_RD_L: begin
        state_nxt = pexpr_pkg::ST_RD_R;
      end
      pexpr_pkg::ST_RD_R: begin
        left_nxt  = (count_r != '0) ? rdata_r : '0;
        state_nxt = pexpr_pkg::ST_POP;
      end
      pexpr_pkg::ST_POP: begin
        right_nxt = right_val;
        if (!has_two) begin
          marks_nxt[pexpr_pkg::MARK_EMPTY] = 1'b1;
        end
        count_nxt = has_two ? cnt_m2 : '0;
        case (char_r)
          pexpr_pkg::CH_PLUS, pexpr_pkg::CH_MINUS, pexpr_pkg::CH_STAR: begin
            state_nxt = pexpr_pkg::ST_ALU;
          end
          pexpr_pkg::CH_SLASH: begin
            if (right_val == '0) begin
              marks_nxt[pexpr_pkg::MARK_DIV0] = 1'b1;
              res_nxt   = '0;
              state_nxt = pexpr_pkg::ST_PUSH;
            end else begin
              quo_nxt   = left_r[DW-1] ? -left_r : left_r;
              dvs_nxt   = right_val[DW-1] ? -right_val : right_val;
              rem_nxt   = '0;
              neg_nxt   = left_r[DW-1] ^ right_val[DW-1];
              step_nxt  = '0;
              state_nxt = pexpr_pkg::ST_DIV;
            end
          end
          default: begin
            unk_nxt   = 1'b1;
            state_nxt = pexpr_pkg::ST_RD_TOP;
          end
        endcase
      end
      pexpr_pkg::ST_ALU: begin
        case (char_r)
          pexpr_pkg::CH_PLUS:  res_nxt = left_r + right_r;
          pexpr_pkg::CH_MINUS: res_nxt = left_r - right_r;
          default:             res_nxt = left_r * right_r;
        endcase
        state_nxt = pexpr_pkg::ST_PUSH;
      end
      pexpr_pkg::ST_DIV: begin
        if (!diff[DW+1]) begin
          rem_nxt = diff[DW-1:0];
          quo_nxt = {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DW-1:0];
          quo_nxt = {quo_r[DW-2:0], 1'b0};
        end
        step_nxt = step_r + SW'(1);
        if (step_r == pexpr_pkg::DIV_LAST_STEP) begin
          state_nxt = pexpr_pkg::ST_DIV_FIX;
        end
      end
      pexpr_pkg::ST_DIV_FIX: begin
        res_nxt   = neg_r ? -quo_r : quo_r;
        state_nxt = pexpr_pkg::ST_PUSH;
      end
      pexpr_pkg::ST_PUSH: begin
        we        = 1'b1;
        wdata     = res_r;
        count_nxt = count_r + CW'(1);
        state_nxt = last_r ? pexpr_pkg::ST_RD_TOP : pexpr_pkg::ST_IDLE;
      end
      pexpr_pkg::ST_RD_TOP: begin
        state_nxt = pexpr_pkg::ST_OUT;
      end
      pexpr_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_nxt.result_value        = (count_r == '0) ? '0 : rdata_r;
          out_nxt.stack_full_seen     = marks_r[pexpr_pkg::MARK_FULL];
          out_nxt.stack_empty_seen    = marks_r[pexpr_pkg::MARK_EMPTY] | (count_r == '0);
          out_nxt.divide_by_zero_seen = marks_r[pexpr_pkg::MARK_DIV0];
          out_nxt.stopped_on_unknown  = unk_r;
          if (last_r) begin
            count_nxt = '0;
            marks_nxt = '0;
            skip_nxt  = 1'b0;
          end else begin
            skip_nxt = 1'b1;
          end
          state_nxt = pexpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pexpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pexpr_pkg::ST_IDLE;
      count_r     <= '0;
      marks_r     <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      marks_r     <= marks_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
    unk_r   <= unk_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    res_r   <= res_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_r   <= neg_nxt;
    step_r  <= step_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  `PEXPR_ASSERT_IMP(a_out_load_from_seq, $rose(out_valid_r),
                    $past(state_r == pexpr_pkg::ST_OUT))
  `PEXPR_ASSERT_NXT(a_div_ends,
                    (state_r == pexpr_pkg::ST_DIV) && (step_r == pexpr_pkg::DIV_LAST_STEP),
                    state_r == pexpr_pkg::ST_DIV_FIX)
  `PEXPR_ASSERT_NXT(a_skip_clears,
                    in_valid && in_ready && skip_r && in_data.final_char,
                    (count_r == '0) && (marks_r == '0) && !skip_r)
  `PEXPR_ASSERT_IMP(a_push_has_room, state_r == pexpr_pkg::ST_PUSH,
                    count_r < CW'(STACK_DEPTH))

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned ITEM_TARGET = 1150;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  pexpr_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready;
  pexpr_pkg::out_t out_data;

  logic [31:0]     operand_mem [STACK_DEPTH];
  int unsigned     operand_count = 0;
  bit              seen_full = 1'b0;
  bit              seen_empty = 1'b0;
  bit              seen_div0 = 1'b0;
  bit              skip_rest = 1'b0;
  pexpr_pkg::out_t predicted_results [$];
  int unsigned     mismatches = 0;
  int unsigned     counted_items = 0;
  bit              no_gaps = 1'b0;
  int unsigned     receiver_hold = 0;

  prefix_expression_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_expression();
    operand_count = 0;
    seen_full     = 1'b0;
    seen_empty    = 1'b0;
    seen_div0     = 1'b0;
    skip_rest     = 1'b0;
  endfunction

  function automatic void push_operand(logic [31:0] value);
    if (operand_count >= STACK_DEPTH) begin
      seen_full = 1'b1;
    end else begin
      operand_mem[operand_count] = value;
      operand_count++;
    end
  endfunction

  function automatic logic [31:0] top_operand();
    if (operand_count == 0) begin
      seen_empty = 1'b1;
      return '0;
    end
    return operand_mem[operand_count-1];
  endfunction

  function automatic void pop_operand();
    if (operand_count == 0) begin
      seen_empty = 1'b1;
    end else begin
      operand_count--;
    end
  endfunction

  function automatic void expect_result(logic [31:0] value, bit stopped);
    pexpr_pkg::out_t r;
    r.result_value        = value;
    r.stack_full_seen     = seen_full;
    r.stack_empty_seen    = seen_empty;
    r.divide_by_zero_seen = seen_div0;
    r.stopped_on_unknown  = stopped;
    predicted_results.push_back(r);
  endfunction

  function automatic void evaluate_char(pexpr_pkg::in_t item);
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] top;
    if (skip_rest) begin
      if (item.final_char) clear_expression();
      return;
    end
    if (item.char_code >= pexpr_pkg::CH_ZERO && item.char_code <= pexpr_pkg::CH_NINE) begin
      push_operand(32'(item.char_code - pexpr_pkg::CH_ZERO));
    end else begin
      lhs = top_operand();
      pop_operand();
      rhs = top_operand();
      pop_operand();
      case (item.char_code)
        pexpr_pkg::CH_PLUS: begin
          push_operand(lhs + rhs);
        end
        pexpr_pkg::CH_MINUS: begin
          push_operand(lhs - rhs);
        end
        pexpr_pkg::CH_STAR: begin
          push_operand(lhs * rhs);
        end
        pexpr_pkg::CH_SLASH: begin
          if (rhs == '0) begin
            seen_div0 = 1'b1;
            push_operand('0);
          end else if (lhs == 32'h8000_0000 && rhs == '1) begin
            push_operand(lhs);
          end else begin
            push_operand($signed(lhs) / $signed(rhs));
          end
        end
        default: begin
          top = top_operand();
          expect_result(top, 1'b1);
          if (item.final_char) clear_expression();
          else skip_rest = 1'b1;
          return;
        end
      endcase
    end
    if (item.final_char) begin
      top = top_operand();
      expect_result(top, 1'b0);
      clear_expression();
    end
  endfunction

  function automatic logic [7:0] random_digit();
    return pexpr_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(0, 3))
      0: return pexpr_pkg::CH_PLUS;
      1: return pexpr_pkg::CH_MINUS;
      2: return pexpr_pkg::CH_STAR;
      default: return pexpr_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] random_unknown();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= pexpr_pkg::CH_ZERO && c <= pexpr_pkg::CH_NINE) ||
           c == pexpr_pkg::CH_PLUS || c == pexpr_pkg::CH_MINUS ||
           c == pexpr_pkg::CH_STAR || c == pexpr_pkg::CH_SLASH);
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_char(logic [7:0] code, bit last);
    int unsigned    gap;
    pexpr_pkg::in_t item;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    item.char_code  = code;
    item.final_char = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (!skip_rest) counted_items++;
    evaluate_char(item);
  endtask

  task automatic send_expression(int unsigned n_ops, bit digits_first, int unsigned missing);
    int unsigned digits_left;
    int unsigned ops_left;
    int          depth;
    digits_left = n_ops + 1 - missing;
    ops_left    = n_ops;
    depth       = 0;
    while (digits_left + ops_left > 0) begin
      if (digits_left > 0 &&
          (digits_first || depth < 2 || $urandom_range(0, 1) == 0)) begin
        send_char(random_digit(), digits_left + ops_left == 1);
        digits_left--;
        depth++;
      end else begin
        send_char(random_op(), digits_left + ops_left == 1);
        ops_left--;
        depth--;
      end
    end
  endtask

  task automatic send_stopped_expression();
    int unsigned lead;
    int unsigned tail;
    lead = $urandom_range(0, 4);
    tail = $urandom_range(0, 4);
    repeat (lead) send_char($urandom_range(0, 2) == 0 ? random_op() : random_digit(), 1'b0);
    send_char(random_unknown(), tail == 0);
    for (int i = 0; i < tail; i++) send_char(8'($urandom_range(0, 255)), i == tail - 1);
  endtask

  task automatic send_noise();
    int unsigned len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      send_char($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : random_op(), i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_char(pexpr_pkg::CH_NINE, 1'b0);
    send_char(8'h33, 1'b0);
    send_char(pexpr_pkg::CH_PLUS, 1'b1);
    send_char(8'h37, 1'b0);
    send_char(8'h33, 1'b0);
    send_char(pexpr_pkg::CH_MINUS, 1'b1);
    send_char(pexpr_pkg::CH_NINE, 1'b0);
    send_char(8'h38, 1'b0);
    send_char(pexpr_pkg::CH_STAR, 1'b1);
    // truncate a negative quotient toward zero
    send_char(8'h33, 1'b0);
    send_char(8'h37, 1'b0);
    send_char(8'h33, 1'b0);
    send_char(pexpr_pkg::CH_MINUS, 1'b0);
    send_char(pexpr_pkg::CH_SLASH, 1'b1);
    send_char(pexpr_pkg::CH_ZERO, 1'b0);
    send_char(8'h35, 1'b0);
    send_char(pexpr_pkg::CH_SLASH, 1'b1);
    send_char(pexpr_pkg::CH_PLUS, 1'b1);
    send_char(8'h34, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h35, 1'b0);
    send_char(pexpr_pkg::CH_PLUS, 1'b1);
    send_char(8'h31, 1'b0);
    send_char(8'h32, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_min_over_minus_one();
    send_char(8'h31, 1'b0);
    send_char(pexpr_pkg::CH_ZERO, 1'b0);
    send_char(pexpr_pkg::CH_MINUS, 1'b0);
    send_char(8'h38, 1'b0);
    repeat (9) begin
      send_char(8'h38, 1'b0);
      send_char(pexpr_pkg::CH_STAR, 1'b0);
    end
    send_char(8'h32, 1'b0);
    send_char(pexpr_pkg::CH_STAR, 1'b0);
    send_char(pexpr_pkg::CH_SLASH, 1'b1);
  endtask

  task automatic test_stack_full();
    send_expression(STACK_DEPTH, 1'b1, 0);
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (15) send_expression($urandom_range(0, 4), 1'b0, 0);
    no_gaps = 1'b0;
  endtask

  task automatic test_output_backpressure();
    receiver_hold = 200;
    repeat (12) send_expression(0, 1'b0, 0);
    repeat (4) send_expression($urandom_range(1, 3), 1'b0, 0);
  endtask

  task automatic test_random_expressions();
    int unsigned pick;
    while (counted_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) send_expression($urandom_range(0, 6), 1'b0, 0);
      else if (pick < 65) send_expression($urandom_range(7, 12), 1'b0, 0);
      else if (pick < 72) send_expression($urandom_range(14, 20), 1'b1, 0);
      else if (pick < 80) send_expression($urandom_range(1, 5), 1'b0, $urandom_range(1, 2));
      else if (pick < 90) send_stopped_expression();
      else send_noise();
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (receiver_hold > 0) begin
        stall = receiver_hold;
        receiver_hold = 0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    pexpr_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.result_value, '0);
      end else begin
        want = predicted_results.pop_front();
        if (out_data.result_value !== want.result_value)
          report_mismatch("result_value", out_data.result_value, want.result_value);
        if (out_data.stack_full_seen !== want.stack_full_seen)
          report_mismatch("stack_full_seen", 32'(out_data.stack_full_seen),
                          32'(want.stack_full_seen));
        if (out_data.stack_empty_seen !== want.stack_empty_seen)
          report_mismatch("stack_empty_seen", 32'(out_data.stack_empty_seen),
                          32'(want.stack_empty_seen));
        if (out_data.divide_by_zero_seen !== want.divide_by_zero_seen)
          report_mismatch("divide_by_zero_seen", 32'(out_data.divide_by_zero_seen),
                          32'(want.divide_by_zero_seen));
        if (out_data.stopped_on_unknown !== want.stopped_on_unknown)
          report_mismatch("stopped_on_unknown", 32'(out_data.stopped_on_unknown),
                          32'(want.stopped_on_unknown));
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    clear_expression();
    test_directed();
    test_min_over_minus_one();
    test_stack_full();
    test_back_to_back();
    test_output_backpressure();
    test_random_expressions();
    in_valid <= 1'b0;
    wait (predicted_results.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
